### hdl/lrg_pkg.sv
// Shared types and constants for the lonely runner exact gap block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
package lrg_pkg;

	localparam int unsigned MAX_SPEEDS_DEF = 9;
	localparam int unsigned MAX_DENOM_DEF  = 256;
	localparam int unsigned SPEED_W        = 8;
	localparam int unsigned THETA_W        = 16;
	localparam int unsigned GAP_NUM_W      = 8;
	localparam int unsigned GAP_DEN_W      = 9;
	localparam int unsigned COUNT_OUT_W    = 4;

	typedef enum logic [1:0] {
		STAT_SKIP    = 2'd0,
		STAT_MEETS   = 2'd1,
		STAT_BELOW   = 2'd2,
		STAT_COUNTER = 2'd3
	} status_t;

	typedef enum logic {
		REG_THETA_NUM = 1'b0,
		REG_THETA_DEN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               last_speed;
	} lrg_in_t;

	typedef struct packed {
		status_t                status;
		logic [GAP_NUM_W-1:0]   gap_num;
		logic [GAP_DEN_W-1:0]   gap_den;
		logic [COUNT_OUT_W-1:0] runner_count;
	} lrg_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PGCD,
		S_LGCD,
		S_MOD_GO,
		S_MOD_WAIT,
		S_PAIR,
		S_EVAL_MUL,
		S_EVAL_CMP,
		S_RED_GO,
		S_RED_GCD,
		S_RED_NUM,
		S_RED_DEN,
		S_CMP_MUL,
		S_CMP,
		S_EMIT
	} state_t;

endpackage

### hdl/lonely_runner_exact_gap_unit.sv
// Lonely runner exact gap unit: collects a speed set and finds its exact maximal minimum gap.
// Sequence: a non-last item runs one prefix gcd pass, unless the set is full and it is dropped;
// a closing item runs the gcd; if it is 1, each denominator d gets a residue setup (one
// division per speed) and a scan of c up to d/2, then a reduction gcd, two divisions and
// the theta compare follow (divisions at the denominator width, 9 bits by default).
// One item at a time: item_stall holds new items off while the unit is not idle.
// Reset: asynchronous, active low; clears control state and sets theta to 1/4.
`timescale 1ns / 1ps
module lonely_runner_exact_gap_unit #(
	parameter int unsigned MAX_SPEEDS = lrg_pkg::MAX_SPEEDS_DEF,
	parameter int unsigned MAX_DENOM  = lrg_pkg::MAX_DENOM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  lrg_pkg::lrg_in_t                item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output lrg_pkg::lrg_out_t               result,
	input  logic                            cfg_we,
	input  lrg_pkg::cfg_reg_t               cfg_idx,
	input  logic [lrg_pkg::THETA_W-1:0]     cfg_wdata
);
	import lrg_pkg::*;

	// Denominator width: wide enough for MAX_DENOM and for 2m with an 8-bit speed.
	localparam int unsigned DW = ($clog2(MAX_DENOM + 1) > 9) ? $clog2(MAX_DENOM + 1) : 9;
	localparam int unsigned IW = (MAX_SPEEDS > 1) ? $clog2(MAX_SPEEDS) : 1;
	localparam int unsigned CW = $clog2(MAX_SPEEDS + 1);

	state_t state_q, state_d;

	// Configuration registers.
	logic [THETA_W-1:0] theta_num_q;
	logic [THETA_W-1:0] theta_den_q;

	// Set collection.
	logic [SPEED_W-1:0] speed_q [MAX_SPEEDS];
	logic [CW-1:0]      count_q;
	logic [SPEED_W-1:0] prefix_q;
	logic [CW-1:0]      k_q;

	// Search state.
	logic [DW-1:0] mod_q [MAX_SPEEDS];
	logic [DW-1:0] res_q [MAX_SPEEDS];
	logic [IW-1:0] i_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] dmax_q;
	logic [DW-1:0] c_q;
	logic [DW-1:0] mn_q;
	logic [DW-1:0] best_num_q;
	logic [DW-1:0] best_den_q;
	logic [2*DW-1:0] prod_a_q;
	logic [2*DW-1:0] prod_b_q;

	// Reduction and classification.
	logic [DW-1:0]         g_q;
	logic [DW-1:0]         pn_q;
	logic [DW-1:0]         pd_q;
	logic [DW+THETA_W-1:0] pt_a_q;
	logic [DW+THETA_W-1:0] pt_b_q;
	logic [DW+CW:0]        pk_q;
	status_t               status_q;

	logic     result_valid_q;
	lrg_out_t result_q;

	// Shared units.
	logic          gcd_start;
	logic [DW-1:0] gcd_a;
	logic [DW-1:0] gcd_b;
	unit_stat_t    gcd_stat;
	logic [DW-1:0] gcd_res;
	logic          div_start;
	logic [DW-1:0] div_dvd;
	logic [DW-1:0] div_dvs;
	unit_stat_t    div_stat;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	lrg_gcd #(.W(DW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (gcd_a),
		.b      (gcd_b),
		.stat   (gcd_stat),
		.result (gcd_res)
	);

	lrg_div #(.W(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	logic          accept;
	logic          emit;
	logic          i_last;
	logic          c_last;
	logic [DW-1:0] twom;
	logic [DW:0]   r_sum;
	logic [DW:0]   r_red;
	logic [DW-1:0] r_new;
	logic [DW-1:0] r_cmp;
	logic [DW-1:0] r_near;
	logic [DW-1:0] mn_new;

	assign accept = item_valid && !item_stall;
	assign emit   = (state_q == S_EMIT) && (!result_valid_q || !result_stall);
	assign i_last = CW'(i_q) == (k_q - 1'b1);
	assign c_last = c_q == (d_q >> 1);
	assign twom   = DW'({item.speed, 1'b0});

	// One step of the scan: advance the residue of speed i by its step and fold its
	// circular distance into the running minimum for this fraction.
	assign r_sum  = {1'b0, res_q[i_q]} + {1'b0, mod_q[i_q]};
	assign r_red  = (r_sum >= {1'b0, d_q}) ? (r_sum - {1'b0, d_q}) : r_sum;
	assign r_new  = r_red[DW-1:0];
	assign r_cmp  = d_q - r_new;
	assign r_near = (r_new <= r_cmp) ? r_new : r_cmp;
	assign mn_new = (r_near < mn_q) ? r_near : mn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and the start strobes of the shared units.
	always_comb begin
		state_d   = state_q;
		gcd_start = 1'b0;
		gcd_a     = best_num_q;
		gcd_b     = best_den_q;
		div_start = 1'b0;
		div_dvd   = {{(DW - SPEED_W){1'b0}}, speed_q[i_q]};
		div_dvs   = d_q;
		unique case (state_q)
			S_IDLE: begin
				gcd_a = {{(DW - SPEED_W){1'b0}}, prefix_q};
				gcd_b = {{(DW - SPEED_W){1'b0}}, item.speed};
				if (accept) begin
					if (item.last_speed) begin
						gcd_start = 1'b1;
						state_d   = S_LGCD;
					end else if (count_q < CW'(MAX_SPEEDS - 1)) begin
						gcd_start = 1'b1;
						state_d   = S_PGCD;
					end
				end
			end
			S_PGCD: begin
				if (gcd_stat.done) begin
					state_d = S_IDLE;
				end
			end
			S_LGCD: begin
				if (gcd_stat.done) begin
					if (gcd_res != DW'(1)) begin
						state_d = S_EMIT;
					end else if (dmax_q < DW'(2)) begin
						state_d = S_RED_GO;
					end else begin
						state_d = S_MOD_GO;
					end
				end
			end
			S_MOD_GO: begin
				div_start = 1'b1;
				state_d   = S_MOD_WAIT;
			end
			S_MOD_WAIT: begin
				if (div_stat.done) begin
					state_d = i_last ? S_PAIR : S_MOD_GO;
				end
			end
			S_PAIR: begin
				if (i_last) begin
					state_d = S_EVAL_MUL;
				end
			end
			S_EVAL_MUL: begin
				state_d = S_EVAL_CMP;
			end
			S_EVAL_CMP: begin
				if (!c_last) begin
					state_d = S_PAIR;
				end else if (d_q == dmax_q) begin
					state_d = S_RED_GO;
				end else begin
					state_d = S_MOD_GO;
				end
			end
			S_RED_GO: begin
				gcd_start = 1'b1;
				state_d   = S_RED_GCD;
			end
			S_RED_GCD: begin
				div_dvd = best_num_q;
				div_dvs = gcd_res;
				if (gcd_stat.done) begin
					div_start = 1'b1;
					state_d   = S_RED_NUM;
				end
			end
			S_RED_NUM: begin
				div_dvd = best_den_q;
				div_dvs = g_q;
				if (div_stat.done) begin
					div_start = 1'b1;
					state_d   = S_RED_DEN;
				end
			end
			S_RED_DEN: begin
				if (div_stat.done) begin
					state_d = S_CMP_MUL;
				end
			end
			S_CMP_MUL: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers with reset: set bookkeeping, thresholds and the result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			prefix_q       <= '0;
			theta_num_q    <= THETA_W'(1);
			theta_den_q    <= THETA_W'(4);
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_THETA_NUM: theta_num_q <= cfg_wdata;
					REG_THETA_DEN: theta_den_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept && !item.last_speed && (count_q < CW'(MAX_SPEEDS - 1))) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_PGCD && gcd_stat.done) begin
				prefix_q <= gcd_res[SPEED_W-1:0];
			end
			if (emit) begin
				count_q        <= '0;
				prefix_q       <= '0;
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (item.last_speed) begin
				speed_q[count_q[IW-1:0]] <= item.speed;
				k_q                      <= count_q + 1'b1;
				dmax_q <= (twom > DW'(MAX_DENOM)) ? DW'(MAX_DENOM) : twom;
			end else if (count_q < CW'(MAX_SPEEDS - 1)) begin
				speed_q[count_q[IW-1:0]] <= item.speed;
			end
		end
		case (state_q)
			S_LGCD: begin
				best_num_q <= '0;
				best_den_q <= DW'(1);
				d_q        <= DW'(2);
				i_q        <= '0;
				status_q   <= STAT_SKIP;
				pn_q       <= '0;
				pd_q       <= DW'(1);
			end
			S_MOD_WAIT: begin
				if (div_stat.done) begin
					mod_q[i_q] <= div_rem;
					res_q[i_q] <= '0;
					if (i_last) begin
						i_q  <= '0;
						c_q  <= DW'(1);
						mn_q <= d_q;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
			end
			S_PAIR: begin
				res_q[i_q] <= r_new;
				mn_q       <= mn_new;
				i_q        <= i_q + 1'b1;
			end
			S_EVAL_MUL: begin
				prod_a_q <= mn_q * best_den_q;
				prod_b_q <= best_num_q * d_q;
			end
			S_EVAL_CMP: begin
				if (prod_a_q > prod_b_q) begin
					best_num_q <= mn_q;
					best_den_q <= d_q;
				end
				i_q <= '0;
				if (!c_last) begin
					c_q  <= c_q + 1'b1;
					mn_q <= d_q;
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			S_RED_GCD: begin
				g_q <= gcd_res;
			end
			S_RED_NUM: begin
				if (div_stat.done) begin
					pn_q <= div_quo;
				end
			end
			S_RED_DEN: begin
				if (div_stat.done) begin
					pd_q <= div_quo;
				end
			end
			S_CMP_MUL: begin
				pt_a_q <= pn_q * theta_den_q;
				pt_b_q <= theta_num_q * pd_q;
				pk_q   <= pn_q * ({1'b0, k_q} + 1'b1);
			end
			S_CMP: begin
				if (pt_a_q >= pt_b_q) begin
					status_q <= STAT_MEETS;
				end else if (pk_q < (DW + CW + 1)'(pd_q)) begin
					status_q <= STAT_COUNTER;
				end else begin
					status_q <= STAT_BELOW;
				end
			end
			default: ;
		endcase
		if (emit) begin
			result_q.status       <= status_q;
			result_q.gap_num      <= pn_q[GAP_NUM_W-1:0];
			result_q.gap_den      <= pd_q[GAP_DEN_W-1:0];
			result_q.runner_count <= COUNT_OUT_W'(k_q);
		end
	end

	assign item_stall   = state_q != S_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The gcd unit and the divider are never used at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(gcd_stat.busy && div_stat.busy))
		else $error("gcd unit and divider busy together");

	// The scanned denominator stays within its bounds while the residues are worked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAIR || state_q == S_MOD_GO) |-> (d_q >= DW'(2) && d_q <= dmax_q))
		else $error("denominator out of range during scan");

	// The best gap never exceeds one half.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED_GO) |-> ({best_num_q, 1'b0} <= {1'b0, best_den_q}))
		else $error("best gap above one half");

	// A skipped set always reports the gap 0/1.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == STAT_SKIP) |->
			(result.gap_num == '0 && result.gap_den == GAP_DEN_W'(1)))
		else $error("skipped set with a nonzero gap");

endmodule

### hdl/lrg_gcd.sv
// Iterative subtractive gcd unit, one compare and subtract per cycle.
// Depends on lrg_pkg for the unit status type.
`timescale 1ns / 1ps
module lrg_gcd #(
	parameter int unsigned W = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	output lrg_pkg::unit_stat_t stat,
	output logic [W-1:0]        result
);
	import lrg_pkg::*;

	logic         busy_q;
	logic         done_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] res_q;
	logic         finish;

	assign finish = busy_q && !start && ((a_q == '0) || (b_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			if (start) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (a_q == '0) begin
				res_q <= b_q;
			end else if (b_q == '0) begin
				res_q <= a_q;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = res_q;

endmodule

### hdl/lrg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lrg_pkg for the unit status type. The divisor must be nonzero.
`timescale 1ns / 1ps
module lrg_div #(
	parameter int unsigned W = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        dividend,
	input  logic [W-1:0]        divisor,
	output lrg_pkg::unit_stat_t stat,
	output logic [W-1:0]        quotient,
	output logic [W-1:0]        remainder
);
	import lrg_pkg::*;

	localparam int unsigned CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
